// ===== rtl/sha1_hash_engine_defines.svh =====
// Assertion macros shared by the SHA-1 engine checker.
// No dependencies; included by files that carry assertions.
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// same-cycle implication
`define SHA1_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1 check failed");

// next-cycle implication
`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1 check failed");

`endif

// ===== rtl/sha1_pkg.sv =====
// Types and constants of the SHA-1 hash engine.
// No dependencies; used by every module of the engine.
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LineBits   = BlockBytes * 8;
   localparam int unsigned FillBits   = $clog2(BlockBytes);
   localparam int unsigned RoundBits  = 7;

   localparam logic [FillBits-1:0]  FILL_MAX       = 6'd63;
   localparam logic [FillBits-1:0]  FILL_LEN_START = 6'd56;
   localparam logic [RoundBits-1:0] ROUND_F1_START = 7'd20;
   localparam logic [RoundBits-1:0] ROUND_F2_START = 7'd40;
   localparam logic [RoundBits-1:0] ROUND_F3_START = 7'd60;
   localparam logic [RoundBits-1:0] ROUND_LAST     = 7'd79;
   localparam logic [2:0]           WORD_IDX_LAST  = 3'd4;

   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [63:0] LEN_STEP = 64'd8;

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   typedef logic [31:0] word_type;
   typedef word_type [4:0] chain_type;

   localparam chain_type INIT_CHAIN = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } hash_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       first_of_message;
      logic       last_of_message;
   } req_type;

   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       step;
   } sched_ctrl_type;

endpackage

// ===== rtl/sha1_sched.sv =====
// Block buffer and message schedule: a 16-word shift line.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_sched (
   input  logic                     clock,
   input  sha1_pkg::sched_ctrl_type ctrl,
   output sha1_pkg::word_type       w_t
);

   logic [sha1_pkg::LineBits-1:0] line_ff;
   logic [sha1_pkg::LineBits-1:0] line_in;
   sha1_pkg::word_type            tap_mix;
   sha1_pkg::word_type            w_new;

   assign w_t     = line_ff[sha1_pkg::LineBits-1 -: 32];
   // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
   assign tap_mix = line_ff[sha1_pkg::LineBits-1-32*13 -: 32]
                  ^ line_ff[sha1_pkg::LineBits-1-32*8  -: 32]
                  ^ line_ff[sha1_pkg::LineBits-1-32*2  -: 32]
                  ^ line_ff[sha1_pkg::LineBits-1       -: 32];
   assign w_new   = {tap_mix[30:0], tap_mix[31]};

   always_comb begin
      line_in = line_ff;
      if (ctrl.push) begin
         line_in = {line_ff[sha1_pkg::LineBits-9:0], ctrl.push_byte};
      end else if (ctrl.step) begin
         line_in = {line_ff[sha1_pkg::LineBits-33:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

endmodule

// ===== rtl/sha1_round.sv =====
// One SHA-1 round: round function, constant select and the five-way add.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_round (
   input  sha1_pkg::hash_state_type        cur,
   input  sha1_pkg::word_type              w_t,
   input  logic [sha1_pkg::RoundBits-1:0]  round_idx,
   output sha1_pkg::hash_state_type        nxt
);

   sha1_pkg::word_type f_val;
   sha1_pkg::word_type k_val;
   sha1_pkg::word_type temp;

   always_comb begin
      if (round_idx < sha1_pkg::ROUND_F1_START) begin
         f_val = (cur.b & cur.c) | (~cur.b & cur.d);
         k_val = sha1_pkg::K0;
      end else if (round_idx < sha1_pkg::ROUND_F2_START) begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = sha1_pkg::K1;
      end else if (round_idx < sha1_pkg::ROUND_F3_START) begin
         f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k_val = sha1_pkg::K2;
      end else begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = sha1_pkg::K3;
      end
   end

   assign temp  = {cur.a[26:0], cur.a[31:27]} + f_val + cur.e + k_val + w_t;

   assign nxt.a = temp;
   assign nxt.b = cur.a;
   assign nxt.c = {cur.b[1:0], cur.b[31:2]};
   assign nxt.d = cur.c;
   assign nxt.e = cur.d;

endmodule

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: sequencer, chaining value and digest output.
// Depends on sha1_pkg, sha1_sched and sha1_round.
//
// Usage: message bytes arrive one per request word on req_*; has_byte marks
// a byte as part of the message, first_of_message restarts the hash before
// the byte is taken, last_of_message closes the message after it.
// An item is taken when req_valid is high and req_stall is low.
// The 64th byte of a block starts a compression (load, 80 rounds on the
// one shared round unit, chain add) before the next word is taken.
// A last item is followed by padding at one byte per cycle up to the block
// end, one or two compressions, then five digest words on rsp_*, most
// significant first, word_index 0..4, last_word on the fifth.
// req_stall stays high from the first padding cycle until the fifth digest
// word has been taken; while rsp_stall is high the shown word holds.
// After the fifth word the engine starts a fresh message by itself.
// Reset (synchronous, active high) loads the initial hash words and clears
// the byte count and the bit length; no request is pending afterwards.
`timescale 1ns / 1ps

module sha1_hash_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sha1_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sha1_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type                        state_ff,     state_in;
   sha1_pkg::chain_type              chain_ff,     chain_in;
   logic [sha1_pkg::FillBits-1:0]    fill_ff,      fill_in;
   logic [63:0]                      len_ff,       len_in;
   sha1_pkg::hash_state_type         work_ff,      work_in;
   logic [sha1_pkg::RoundBits-1:0]   round_ff,     round_in;
   logic                             pad_mode_ff,  pad_mode_in;
   logic                             pad80_ff,     pad80_in;
   logic                             final_ff,     final_in;
   logic [2:0]                       idx_ff,       idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             req_accept;
   logic [sha1_pkg::FillBits-1:0]    fill_base;
   logic [63:0]                      len_base;
   logic [7:0]                       pad_byte;
   sha1_pkg::sched_ctrl_type         sched_ctrl;
   sha1_pkg::word_type               w_t;
   sha1_pkg::hash_state_type         round_nxt;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign fill_base  = req_data.first_of_message ? '0 : fill_ff;
   assign len_base   = req_data.first_of_message ? '0 : len_ff;

   always_comb begin
      if (!pad80_ff) begin
         pad_byte = sha1_pkg::PAD_BYTE;
      end else if (final_ff && (fill_ff >= sha1_pkg::FILL_LEN_START)) begin
         pad_byte = len_ff[63:56];
      end else begin
         pad_byte = '0;
      end
   end

   always_comb begin
      sched_ctrl.push      = 1'b0;
      sched_ctrl.push_byte = req_data.data_byte;
      sched_ctrl.step      = (state_ff == ST_ROUND);
      if (state_ff == ST_IDLE) begin
         sched_ctrl.push = req_accept && req_data.has_byte;
      end else if (state_ff == ST_PAD) begin
         sched_ctrl.push      = 1'b1;
         sched_ctrl.push_byte = pad_byte;
      end
   end

   sha1_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_t   (w_t)
   );

   sha1_round u_round (
      .cur       (work_ff),
      .w_t       (w_t),
      .round_idx (round_ff),
      .nxt       (round_nxt)
   );

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      work_in      = work_ff;
      round_in     = round_ff;
      pad_mode_in  = pad_mode_ff;
      pad80_in     = pad80_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.first_of_message) begin
                  chain_in = sha1_pkg::INIT_CHAIN;
               end
               pad_mode_in = req_data.last_of_message;
               pad80_in    = 1'b0;
               final_in    = 1'b0;
               fill_in     = fill_base;
               len_in      = len_base;
               if (req_data.has_byte) begin
                  fill_in = fill_base + 1'b1;
                  len_in  = len_base + sha1_pkg::LEN_STEP;
               end
               if (req_data.has_byte && (fill_base == sha1_pkg::FILL_MAX)) begin
                  state_in = ST_LOAD;
               end else if (req_data.last_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD: begin
            work_in  = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2],
                         d: chain_ff[3], e: chain_ff[4]};
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in  = round_nxt;
            round_in = round_ff + 1'b1;
            if (round_ff == sha1_pkg::ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            if (!pad_mode_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               // data block or overflow block done: length goes in the next one
               if (pad80_ff) begin
                  final_in = 1'b1;
               end
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            fill_in = fill_ff + 1'b1;
            if (!pad80_ff) begin
               pad80_in = 1'b1;
               if (fill_ff < sha1_pkg::FILL_LEN_START) begin
                  final_in = 1'b1;
               end
            end else if (final_ff && (fill_ff >= sha1_pkg::FILL_LEN_START)) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (fill_ff == sha1_pkg::FILL_MAX) begin
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == sha1_pkg::WORD_IDX_LAST) begin
                  chain_in     = sha1_pkg::INIT_CHAIN;
                  fill_in      = '0;
                  len_in       = '0;
                  pad_mode_in  = 1'b0;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= sha1_pkg::INIT_CHAIN;
         fill_ff      <= '0;
         len_ff       <= '0;
         pad_mode_ff  <= 1'b0;
         pad80_ff     <= 1'b0;
         final_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         pad_mode_ff  <= pad_mode_in;
         pad80_ff     <= pad80_in;
         final_ff     <= final_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      round_ff <= round_in;
   end

   always_comb begin
      rsp_data.word_index = idx_ff;
      rsp_data.last_word  = (idx_ff == sha1_pkg::WORD_IDX_LAST);
      case (idx_ff)
         3'd0:    rsp_data.digest_word = chain_ff[0];
         3'd1:    rsp_data.digest_word = chain_ff[1];
         3'd2:    rsp_data.digest_word = chain_ff[2];
         3'd3:    rsp_data.digest_word = chain_ff[3];
         default: rsp_data.digest_word = chain_ff[4];
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/sha1_checker.sv =====
// Port-level checks of the SHA-1 hash engine, bound to the top level.
// Depends on sha1_pkg and sha1_hash_engine_defines.svh.
`timescale 1ns / 1ps
`include "sha1_hash_engine_defines.svh"

module sha1_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sha1_pkg::rsp_type rsp_data
);

   `SHA1_ASSERT_NOW(a_no_req_during_digest, clock, reset, rsp_valid, req_stall)

   `SHA1_ASSERT_NEXT(a_req_word_no_digest, clock, reset, req_valid && !req_stall,
                     !rsp_valid)

   `SHA1_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data))

   `SHA1_ASSERT_NEXT(a_word_advance, clock, reset,
                     rsp_valid && !rsp_stall && !rsp_data.last_word,
                     rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))

   `SHA1_ASSERT_NEXT(a_digest_end, clock, reset,
                     rsp_valid && !rsp_stall && rsp_data.last_word, !rsp_valid)

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
